/* rtl/assert_macros.svh */
// assertion macros used by the display column latch
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/adcl_pkg.sv */
// types, constants and the segment bit permutation for the display column latch
`timescale 1ns / 1ps

package adcl_pkg;

    localparam int LAMP_W   = 12;
    localparam int SEG_W    = 16;
    localparam int COL_IDX_W = 5;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    // control port bit positions
    localparam int BIT_LDATA = 0;
    localparam int BIT_LSTRB = 1;
    localparam int BIT_DDATA = 5;
    localparam int BIT_DSTRB = 6;
    localparam int BIT_DBLNK = 7;

    typedef enum logic [1:0] {
        MODE_PORT   = 2'd0,
        MODE_SEG    = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG_WR,
        ST_UPD_RD,
        ST_UPD_LOAD,
        ST_UPD_WAIT
    } adcl_state_t;

    typedef logic [3:0] perm_tab_t [SEG_W];

    // input bit k lands on output bit SEG_PERM[k]
    localparam perm_tab_t SEG_PERM = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd9, 4'd10,
        4'd11, 4'd12, 4'd13, 4'd14, 4'd6, 4'd8, 4'd15, 4'd7
    };

    function automatic logic [SEG_W-1:0] seg_permute(input logic [SEG_W-1:0] w);
        logic [SEG_W-1:0] r;
        r = '0;
        for (int k = 0; k < SEG_W; k++) begin
            r[SEG_PERM[k]] = w[k];
        end
        return r;
    endfunction

endpackage

/* rtl/alnum_display_column_latch.sv */
// alphanumeric display column latch: control port, segment stores and update walk
`timescale 1ns / 1ps

// Two-row sixteen-segment display latch. Each input transaction carries a mode in
// s_tuser: a control port write (lamp strobe shifts the lamp column register,
// display strobe clears or advances the column counter), a segment byte write
// into the current column, or an update tick. Port writes, the unused mode and a
// dropped segment byte write give one status transaction each; a taken segment
// byte write goes through ST_SEG_WR because it reads, merges and writes back both
// segment memories through their registered read port and write port. An update
// tick walks the ROWS*COLUMNS accumulated words (40 at the defaults), row 0
// first; each word passes through a read, a load and a hand-over state, and the
// walk stalls while m_tready is low. A new transaction is taken only when the
// block is idle and its result register is empty. Both segment stores read as
// zero after reset through per-entry valid bits, so no clearing pass is needed.
module alnum_display_column_latch #(
    parameter int COLUMNS = 20,
    parameter int ROWS    = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // register_select [1:0], data_byte [9:2], zero [15:10]
    input  logic [adcl_pkg::S_DATA_W-1:0]  s_tdata,
    // mode [1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // row_index [0], column_index [5:1], segment_bits [21:6], lamp_column [33:22],
    // zero [39:34]
    output logic [adcl_pkg::M_DATA_W-1:0]  m_tdata,
    // is_segment_word [0]
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import adcl_pkg::*;

`include "assert_macros.svh"

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(COLUMNS + 1);

    adcl_state_t state_reg, state_next;

    logic [7:0]        prev_port_reg, prev_port_next;
    logic [LAMP_W-1:0] lamp_reg, lamp_next;
    logic [CNT_W-1:0]  col_cnt_reg, col_cnt_next;

    logic [ADDR_W-1:0] seg_addr_reg, seg_addr_next;
    logic              seg_hi_reg, seg_hi_next;
    logic [7:0]        seg_data_reg, seg_data_next;

    logic              upd_row_reg, upd_row_next;
    logic [CNT_W-1:0]  upd_col_reg, upd_col_next;

    logic [DEPTH-1:0]  acc_vld_reg, acc_vld_next;
    logic [DEPTH-1:0]  lat_vld_reg, lat_vld_next;

    logic [SEG_W-1:0]  acc_mem [DEPTH];
    logic [SEG_W-1:0]  lat_mem [DEPTH];
    logic [SEG_W-1:0]  acc_rd_reg, lat_rd_reg;
    logic              acc_rd_vld_reg, lat_rd_vld_reg;

    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;
    logic              m_tlast_reg;

    // datapath controls
    logic              accept;
    mode_t             in_mode;
    logic [1:0]        in_sel;
    logic [7:0]        in_data;
    logic [7:0]        port_rise;
    logic              seg_ok;
    logic [ADDR_W-1:0] seg_addr_in;
    logic [ADDR_W-1:0] upd_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              acc_we, lat_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [SEG_W-1:0]  acc_wr_data, lat_wr_data;
    logic [SEG_W-1:0]  acc_old, lat_old, byte_word;
    logic              upd_last;
    logic              out_load;
    logic              out_seg, out_row, out_last;
    logic [CNT_W-1:0]  out_col;
    logic [SEG_W-1:0]  out_bits;
    logic              out_take;

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_mode  = mode_t'(s_tuser);
    assign in_sel   = s_tdata[1:0];
    assign in_data  = s_tdata[9:2];
    assign out_take = m_tvalid_reg && m_tready;

    assign port_rise = in_data & ~prev_port_reg;
    assign seg_ok    = prev_port_reg[BIT_DBLNK] && (col_cnt_reg < CNT_W'(COLUMNS))
                       && ((ROWS > 1) || !in_sel[1]);
    assign seg_addr_in = (in_sel[1] ? ADDR_W'(COLUMNS) : '0)
                         + ADDR_W'(col_cnt_reg);
    assign upd_addr    = (upd_row_reg ? ADDR_W'(COLUMNS) : '0)
                         + ADDR_W'(upd_col_reg);
    assign upd_last    = (upd_row_reg == 1'(ROWS - 1))
                         && (upd_col_reg == CNT_W'(COLUMNS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_mode == MODE_SEG) && seg_ok) begin
                    state_next = ST_SEG_WR;
                end else if (accept && (in_mode == MODE_UPDATE)) begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_SEG_WR:   state_next = ST_IDLE;
            ST_UPD_RD:   state_next = ST_UPD_LOAD;
            ST_UPD_LOAD: state_next = ST_UPD_WAIT;
            ST_UPD_WAIT: begin
                if (out_take) begin
                    state_next = m_tlast_reg ? ST_IDLE : ST_UPD_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        prev_port_next = prev_port_reg;
        lamp_next      = lamp_reg;
        col_cnt_next   = col_cnt_reg;
        seg_addr_next  = seg_addr_reg;
        seg_hi_next    = seg_hi_reg;
        seg_data_next  = seg_data_reg;
        upd_row_next   = upd_row_reg;
        upd_col_next   = upd_col_reg;
        acc_vld_next   = acc_vld_reg;
        lat_vld_next   = lat_vld_reg;
        rd_addr        = upd_addr;
        acc_we         = 1'b0;
        lat_we         = 1'b0;
        wr_addr        = seg_addr_reg;
        acc_old        = acc_rd_vld_reg ? acc_rd_reg : '0;
        lat_old        = lat_rd_vld_reg ? lat_rd_reg : '0;
        byte_word      = seg_hi_reg ? {seg_data_reg, 8'h00} : {8'h00, seg_data_reg};
        acc_wr_data    = acc_old | byte_word;
        lat_wr_data    = seg_hi_reg ? {seg_data_reg, lat_old[7:0]}
                                    : {lat_old[15:8], seg_data_reg};
        out_load       = 1'b0;
        out_seg        = 1'b0;
        out_row        = 1'b0;
        out_col        = col_cnt_reg;
        out_bits       = '0;
        out_last       = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = seg_addr_in;
                if (accept) begin
                    unique case (in_mode)
                        MODE_PORT: begin
                            prev_port_next = in_data;
                            if (port_rise[BIT_LSTRB]) begin
                                lamp_next = {lamp_reg[LAMP_W-2:0], in_data[BIT_LDATA]};
                            end
                            if (port_rise[BIT_DSTRB]) begin
                                if (in_data[BIT_DDATA]) begin
                                    col_cnt_next = '0;
                                end else if (col_cnt_reg < CNT_W'(COLUMNS)) begin
                                    col_cnt_next = col_cnt_reg + 1'b1;
                                end
                            end
                            out_load = 1'b1;
                            out_col  = col_cnt_next;
                        end
                        MODE_SEG: begin
                            seg_addr_next = seg_addr_in;
                            seg_hi_next   = in_sel[0];
                            seg_data_next = in_data;
                            // an ignored write answers at once
                            out_load      = !seg_ok;
                        end
                        MODE_UPDATE: begin
                            upd_row_next = 1'b0;
                            upd_col_next = '0;
                        end
                        MODE_NONE: begin
                            out_load = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEG_WR: begin
                acc_we   = 1'b1;
                lat_we   = 1'b1;
                acc_vld_next[seg_addr_reg] = 1'b1;
                lat_vld_next[seg_addr_reg] = 1'b1;
                out_load = 1'b1;
            end
            ST_UPD_RD: ;
            ST_UPD_LOAD: begin
                // reload the accumulator from the latest word
                wr_addr     = upd_addr;
                acc_we      = 1'b1;
                acc_wr_data = lat_old;
                acc_vld_next[upd_addr] = 1'b1;
                out_load    = 1'b1;
                out_seg     = 1'b1;
                out_row     = upd_row_reg;
                out_col     = upd_col_reg;
                out_bits    = seg_permute(acc_old);
                out_last    = upd_last;
            end
            ST_UPD_WAIT: begin
                if (out_take && !m_tlast_reg) begin
                    if (upd_col_reg == CNT_W'(COLUMNS - 1)) begin
                        upd_col_next = '0;
                        upd_row_next = 1'b1;
                    end else begin
                        upd_col_next = upd_col_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_port_reg <= '0;
            lamp_reg      <= '0;
            col_cnt_reg   <= '0;
            upd_row_reg   <= 1'b0;
            upd_col_reg   <= '0;
            acc_vld_reg   <= '0;
            lat_vld_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_port_reg <= prev_port_next;
            lamp_reg      <= lamp_next;
            col_cnt_reg   <= col_cnt_next;
            upd_row_reg   <= upd_row_next;
            upd_col_reg   <= upd_col_next;
            acc_vld_reg   <= acc_vld_next;
            lat_vld_reg   <= lat_vld_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (out_take) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        seg_addr_reg <= seg_addr_next;
        seg_hi_reg   <= seg_hi_next;
        seg_data_reg <= seg_data_next;
        if (out_load) begin
            m_tdata_reg <= {6'b0, lamp_next, out_bits, COL_IDX_W'(out_col), out_row};
            m_tuser_reg <= out_seg;
            m_tlast_reg <= out_last;
        end
    end

    // segment memories, registered read
    always_ff @(posedge aclk) begin
        acc_rd_reg     <= acc_mem[rd_addr];
        lat_rd_reg     <= lat_mem[rd_addr];
        acc_rd_vld_reg <= acc_vld_reg[rd_addr];
        lat_rd_vld_reg <= lat_vld_reg[rd_addr];
        if (acc_we) begin
            acc_mem[wr_addr] <= acc_wr_data;
        end
        if (lat_we) begin
            lat_mem[wr_addr] <= lat_wr_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_ALWAYS(a_col_sat, col_cnt_reg <= CNT_W'(COLUMNS), "column counter past saturation")
    `ASSERT_ALWAYS(a_rdy_empty, !(s_tready && m_tvalid_reg), "input ready with result pending")
    `ASSERT_NEXT(a_seg_done, state_reg == ST_SEG_WR, m_tvalid_reg && state_reg == ST_IDLE,
        "segment write gave no status")
    `ASSERT_NEXT(a_last_idle, out_take && m_tlast_reg, state_reg == ST_IDLE,
        "sequencer busy after final transaction")
    `ASSERT_NEXT(a_upd_word, state_reg == ST_UPD_LOAD, m_tvalid_reg && m_tuser_reg,
        "update step gave no display word")

endmodule
